/* design/srl_pkg.sv */
// Shared types, constants and the hex-digit decoder for the S-record loader.
`default_nettype none

package srl_pkg;

    // Result kinds carried on the kind output.
    typedef enum logic [2:0] {
        KIND_WRITE   = 3'd0,
        KIND_END     = 3'd1,
        KIND_NOSTART = 3'd2,
        KIND_BADTYPE = 3'd3,
        KIND_BADHEX  = 3'd4
    } kind_t;

    localparam logic [7:0] CHAR_S       = 8'h53;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] HEADER_BYTES = 8'd3;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // Decodes one ASCII hex digit; ok is low for any other character.
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.value = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.value = 4'(c - 8'h57);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

/* design/srecord_loader_core.sv */
// S-record loader core: parses S1/S9 text one character per transfer into byte writes.
//
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------------
// input    | in        | in_valid / in_stall    | text_char[7:0]
// output   | out       | out_valid / out_stall  | kind[2:0], write_address, write_data
// config   | in        | cfg_valid / cfg_ready  | address_offset[15:0]
//
// One character is taken per cycle unless the input stalls: it is held in an input register,
// decoded by the parser logic and any resulting write or status lands in the output register.
// Output valid rises once the result is registered in the output stage; sustained rate is one
// character per cycle while the output side does not stall.
// A stalled output only holds the input stage when the pending character yields a result.
// Reset clears the parser state, the offset and both stages; the config port is always ready.
`default_nettype none

module srecord_loader_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  text_char,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [15:0]      write_address,
    output logic [7:0]       write_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] address_offset
);

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_TYPE  = 3'd1,
        PH_LEN   = 3'd2,
        PH_ADDR  = 3'd3,
        PH_DATA  = 3'd4,
        PH_SKIP  = 3'd5
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [7:0]     length_count_reg, length_count_next;
    logic [15:0]    load_address_reg, load_address_next;
    logic [3:0]     high_nibble_reg, high_nibble_next;
    logic [1:0]     digit_position_reg, digit_position_next;
    logic           halted_reg, halted_next;
    logic [15:0]    offset_reg;

    logic           char_valid_reg;
    logic [7:0]     char_reg;

    logic           out_valid_reg;
    srl_pkg::kind_t kind_reg;
    logic [15:0]    write_address_reg;
    logic [7:0]     write_data_reg;

    logic           emit;
    srl_pkg::kind_t emit_kind;
    logic [15:0]    emit_address;
    logic [7:0]     emit_data;
    logic           advance;
    srl_pkg::hex_t  hex;
    logic [15:0]    full_address;
    logic [7:0]     length_left;

    assign hex          = srl_pkg::hex_decode(char_reg);
    assign full_address = {load_address_reg[11:0], hex.value} - offset_reg;
    assign length_left  = length_count_reg - 8'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        length_count_next   = length_count_reg;
        load_address_next   = load_address_reg;
        high_nibble_next    = high_nibble_reg;
        digit_position_next = digit_position_reg;
        halted_next         = halted_reg;
        emit                = 1'b0;
        emit_kind           = srl_pkg::KIND_WRITE;
        emit_address        = 16'd0;
        emit_data           = 8'd0;

        if (!halted_reg)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (char_reg != srl_pkg::CHAR_S)
                    begin
                        emit      = 1'b1;
                        emit_kind = srl_pkg::KIND_NOSTART;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (char_reg == srl_pkg::CHAR_NINE)
                    begin
                        emit      = 1'b1;
                        emit_kind = srl_pkg::KIND_END;
                    end
                    else if (char_reg != srl_pkg::CHAR_ONE)
                    begin
                        emit      = 1'b1;
                        emit_kind = srl_pkg::KIND_BADTYPE;
                    end
                    else
                    begin
                        phase_next          = PH_LEN;
                        digit_position_next = 2'd0;
                        length_count_next   = 8'd0;
                    end
                end
                PH_SKIP:
                begin
                    if (char_reg == srl_pkg::CHAR_NEWLINE)
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_LEN, PH_ADDR, PH_DATA:
                begin
                    if (!hex.ok)
                    begin
                        emit      = 1'b1;
                        emit_kind = srl_pkg::KIND_BADHEX;
                    end
                    else if (phase_reg == PH_LEN)
                    begin
                        length_count_next = {length_count_reg[3:0], hex.value};
                        if (digit_position_reg == 2'd0)
                        begin
                            digit_position_next = 2'd1;
                        end
                        else
                        begin
                            digit_position_next = 2'd0;
                            load_address_next   = 16'd0;
                            phase_next          = PH_ADDR;
                        end
                    end
                    else if (phase_reg == PH_ADDR)
                    begin
                        if (digit_position_reg != 2'd3)
                        begin
                            load_address_next   = {load_address_reg[11:0], hex.value};
                            digit_position_next = digit_position_reg + 2'd1;
                        end
                        else
                        begin
                            // Last address digit: rebase the address, then data or skip.
                            load_address_next   = full_address;
                            digit_position_next = 2'd0;
                            if (length_count_reg <= srl_pkg::HEADER_BYTES)
                            begin
                                length_count_next = 8'd0;
                                phase_next        = PH_SKIP;
                            end
                            else
                            begin
                                length_count_next = length_count_reg - srl_pkg::HEADER_BYTES;
                                phase_next        = PH_DATA;
                            end
                        end
                    end
                    else
                    begin
                        if (digit_position_reg == 2'd0)
                        begin
                            high_nibble_next    = hex.value;
                            digit_position_next = 2'd1;
                        end
                        else
                        begin
                            emit                = 1'b1;
                            emit_kind           = srl_pkg::KIND_WRITE;
                            emit_address        = load_address_reg;
                            emit_data           = {high_nibble_reg, hex.value};
                            digit_position_next = 2'd0;
                            load_address_next   = load_address_reg + 16'd1;
                            length_count_next   = length_left;
                            if (length_left == 8'd0)
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase

            if (emit && emit_kind != srl_pkg::KIND_WRITE)
            begin
                halted_next = 1'b1;
            end
        end
    end

    // A character moves on unless it has a result and the output slot is still full.
    assign advance   = char_valid_reg && (!emit || !out_valid_reg || !out_stall);
    assign in_stall  = char_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign write_address = write_address_reg;
    assign write_data    = write_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_START;
            length_count_reg   <= 8'd0;
            load_address_reg   <= 16'd0;
            high_nibble_reg    <= 4'd0;
            digit_position_reg <= 2'd0;
            halted_reg         <= 1'b0;
            offset_reg         <= 16'd0;
            char_valid_reg     <= 1'b0;
            char_reg           <= 8'd0;
            out_valid_reg      <= 1'b0;
            kind_reg           <= srl_pkg::KIND_WRITE;
            write_address_reg  <= 16'd0;
            write_data_reg     <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                offset_reg <= address_offset;
            end

            if (!char_valid_reg || advance)
            begin
                char_valid_reg <= in_valid;
                if (in_valid)
                begin
                    char_reg <= text_char;
                end
            end

            if (advance)
            begin
                phase_reg          <= phase_next;
                length_count_reg   <= length_count_next;
                load_address_reg   <= load_address_next;
                high_nibble_reg    <= high_nibble_next;
                digit_position_reg <= digit_position_next;
                halted_reg         <= halted_next;
            end

            if (advance && emit)
            begin
                out_valid_reg     <= 1'b1;
                kind_reg          <= emit_kind;
                write_address_reg <= emit_address;
                write_data_reg    <= emit_data;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    // Any status result other than a byte write must leave the parser halted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != srl_pkg::KIND_WRITE |-> halted_reg)
        else $error("status result without halt");

    // Once halted, only reset resumes parsing.
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    // A halted parser never produces a new result.
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !emit)
        else $error("result produced while halted");

    // The input is only held back by a pending character with a result and a full output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> char_valid_reg && emit && out_valid_reg)
        else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

/* tb/srecord_loader_checker.sv */
// Checker for the S-record loader: predicts results from observed transfers and compares them.
module srecord_loader_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  text_char,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [15:0] write_address,
    input  wire logic [7:0]  write_data,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [15:0] address_offset,
    output int               fail_count,
    output int               pending
);

    typedef enum logic [2:0] {
        AWAIT_S,
        AWAIT_TYPE,
        LEN_DIGITS,
        ADDR_DIGITS,
        DATA_DIGITS,
        SKIP_LINE
    } parse_phase_t;

    typedef struct packed {
        srl_pkg::kind_t k;
        logic [15:0]    addr;
        logic [7:0]     data;
    } loader_event_t;

    loader_event_t predicted_events[$];
    loader_event_t oldest;

    parse_phase_t phase;
    logic [15:0]  offset_reg;
    logic [7:0]   len_count;
    logic [15:0]  load_addr;
    logic [3:0]   hi_nibble;
    logic [1:0]   digit_pos;
    logic         halted;

    // Returns {is_hex, value} for one ASCII character.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return {1'b1, 4'(c - "0")};
        end
        if (c >= "A" && c <= "F")
        begin
            return {1'b1, 4'(c - "A" + 8'd10)};
        end
        if (c >= "a" && c <= "f")
        begin
            return {1'b1, 4'(c - "a" + 8'd10)};
        end
        return 5'd0;
    endfunction

    task automatic post_event(input srl_pkg::kind_t k, input logic [15:0] addr,
                              input logic [7:0] data);
        loader_event_t ev;
        ev.k    = k;
        ev.addr = addr;
        ev.data = data;
        predicted_events.push_back(ev);
        if (k != srl_pkg::KIND_WRITE)
        begin
            halted = 1'b1;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [4:0] nib;
        nib = nibble_of(c);
        if (halted)
        begin
            return;
        end
        case (phase)
            AWAIT_S:
            begin
                if (c != srl_pkg::CHAR_S)
                begin
                    post_event(srl_pkg::KIND_NOSTART, 16'd0, 8'd0);
                end
                else
                begin
                    phase = AWAIT_TYPE;
                end
            end
            AWAIT_TYPE:
            begin
                if (c == srl_pkg::CHAR_NINE)
                begin
                    post_event(srl_pkg::KIND_END, 16'd0, 8'd0);
                end
                else if (c != srl_pkg::CHAR_ONE)
                begin
                    post_event(srl_pkg::KIND_BADTYPE, 16'd0, 8'd0);
                end
                else
                begin
                    phase     = LEN_DIGITS;
                    digit_pos = 2'd0;
                    len_count = 8'd0;
                end
            end
            SKIP_LINE:
            begin
                if (c == srl_pkg::CHAR_NEWLINE)
                begin
                    phase = AWAIT_S;
                end
            end
            default:
            begin
                if (!nib[4])
                begin
                    post_event(srl_pkg::KIND_BADHEX, 16'd0, 8'd0);
                end
                else if (phase == LEN_DIGITS)
                begin
                    len_count = {len_count[3:0], nib[3:0]};
                    if (digit_pos == 2'd0)
                    begin
                        digit_pos = 2'd1;
                    end
                    else
                    begin
                        digit_pos = 2'd0;
                        load_addr = 16'd0;
                        phase     = ADDR_DIGITS;
                    end
                end
                else if (phase == ADDR_DIGITS)
                begin
                    load_addr = {load_addr[11:0], nib[3:0]};
                    if (digit_pos != 2'd3)
                    begin
                        digit_pos = digit_pos + 2'd1;
                    end
                    else
                    begin
                        // The offset in force when the last address digit arrives applies.
                        digit_pos = 2'd0;
                        load_addr = load_addr - offset_reg;
                        if (len_count <= srl_pkg::HEADER_BYTES)
                        begin
                            len_count = 8'd0;
                            phase     = SKIP_LINE;
                        end
                        else
                        begin
                            len_count = len_count - srl_pkg::HEADER_BYTES;
                            phase     = DATA_DIGITS;
                        end
                    end
                end
                else if (digit_pos == 2'd0)
                begin
                    hi_nibble = nib[3:0];
                    digit_pos = 2'd1;
                end
                else
                begin
                    digit_pos = 2'd0;
                    post_event(srl_pkg::KIND_WRITE, load_addr, {hi_nibble, nib[3:0]});
                    load_addr = load_addr + 16'd1;
                    len_count = len_count - 8'd1;
                    if (len_count == 8'd0)
                    begin
                        phase = SKIP_LINE;
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            phase      = AWAIT_S;
            offset_reg = 16'd0;
            len_count  = 8'd0;
            load_addr  = 16'd0;
            hi_nibble  = 4'd0;
            digit_pos  = 2'd0;
            halted     = 1'b0;
            predicted_events.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_events.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected result: kind %0d addr %h data %h",
                                 kind, write_address, write_data);
                    end
                    fail_count = fail_count + 1;
                end
                else
                begin
                    oldest = predicted_events.pop_front();
                    if (kind != oldest.k || write_address != oldest.addr
                        || write_data != oldest.data)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch: expected %0d %h %h, actual %0d %h %h",
                                     oldest.k, oldest.addr, oldest.data,
                                     kind, write_address, write_data);
                        end
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                offset_reg = address_offset;
            end
            if (in_valid && !in_stall)
            begin
                parse_char(text_char);
            end
            pending <= predicted_events.size();
        end
    end

endmodule

/* tb/tb_srecord_loader_core.sv */
// Testbench top for the S-record loader: drives text and offset writes, gives the verdict.
module tb_srecord_loader_core;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TEXT_ITEMS     = 1200;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic [7:0]  text_char      = 8'd0;
    logic        out_stall      = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic [15:0] address_offset = 16'd0;

    wire logic        in_stall;
    wire logic        out_valid;
    wire logic [2:0]  kind;
    wire logic [15:0] write_address;
    wire logic [7:0]  write_data;
    wire logic        cfg_ready;

    int fail_count;
    int pending;
    int idle_cycles  = 0;
    int stall_left   = 0;
    int items_parsed = 0;
    bit took_result  = 1'b0;
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;

    srecord_loader_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_char     (text_char),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .write_address (write_address),
        .write_data    (write_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .address_offset(address_offset)
    );

    srecord_loader_checker check_u (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_char     (text_char),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .write_address (write_address),
        .write_data    (write_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .address_offset(address_offset),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Each result draws its own stall; the count only runs down while a result is offered.
    always @(posedge clk)
    begin
        took_result <= out_valid && !out_stall;
    end

    always @(negedge clk)
    begin
        if (took_result)
        begin
            stall_left = rx_idle ? int'($urandom_range(0, 16)) : 0;
        end
        out_stall <= (stall_left > 0);
        if (out_valid && stall_left > 0)
        begin
            stall_left = stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("srecord_loader_core test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'(8'h30 + n);
        end
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10);
    endfunction

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = tx_idle ? int'($urandom_range(0, 16)) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        text_char <= c;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    task automatic send_hex(input logic [15:0] value, input int digits);
        for (int i = digits - 1; i >= 0; i--)
        begin
            send_char(hex_char(value[4*i +: 4]));
        end
    endtask

    // One S1 line with random data, an optional checksum and some junk before the newline.
    task automatic send_record(input logic [7:0] len, input logic [15:0] addr);
        int         nbytes;
        logic [7:0] junk;
        nbytes = (len > srl_pkg::HEADER_BYTES) ? int'(len - srl_pkg::HEADER_BYTES) : 0;
        send_char(srl_pkg::CHAR_S);
        send_char(srl_pkg::CHAR_ONE);
        send_hex({8'd0, len}, 2);
        send_hex(addr, 4);
        repeat (nbytes) send_hex(16'($urandom_range(0, 255)), 2);
        items_parsed = items_parsed + 8 + 2 * nbytes;
        if ($urandom_range(0, 3) != 0)
        begin
            send_hex(16'($urandom_range(0, 255)), 2);
        end
        repeat ($urandom_range(0, 3))
        begin
            junk = 8'($urandom_range(0, 255));
            send_char(junk == srl_pkg::CHAR_NEWLINE ? 8'h0d : junk);
        end
        send_char(srl_pkg::CHAR_NEWLINE);
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_offset(input logic [15:0] value);
        @(negedge clk);
        cfg_valid      <= 1'b1;
        address_offset <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int         batch_left;
        int         len;
        int         nbytes;
        logic [15:0] addr;
        logic [15:0] offset;
        logic [7:0] bad;
        logic [7:0] c;

        batch_left = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Offset at its top value maps FFFF to zero; then a write that wraps past FFFF.
        write_offset(16'hFFFF);
        send_text("S104FFFFab");
        send_char(8'h00);
        send_char(8'hFF);
        send_char(srl_pkg::CHAR_NEWLINE);
        drain;
        write_offset(16'h0000);
        send_text("S105FFFFC0dE\n");

        while (items_parsed < TEXT_ITEMS)
        begin
            if (batch_left == 0)
            begin
                drain;
                case ($urandom_range(0, 3))
                    0:       offset = 16'h0000;
                    1:       offset = 16'hFFFF;
                    default: offset = 16'($urandom_range(0, 16'hFFFF));
                endcase
                write_offset(offset);
                tx_idle    = ($urandom_range(0, 2) != 0);
                rx_idle    = ($urandom_range(0, 2) != 0);
                batch_left = int'($urandom_range(3, 10));
            end
            if ($urandom_range(0, 39) == 0)
            begin
                len = int'($urandom_range(128, 255));
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                len = int'($urandom_range(0, 3));
            end
            else
            begin
                len = int'($urandom_range(4, 12));
            end
            case ($urandom_range(0, 7))
                0:       addr = 16'h0000;
                1:       addr = 16'hFFFF - 16'($urandom_range(0, 3));
                default: addr = 16'($urandom_range(0, 16'hFFFF));
            endcase
            send_record(8'(len), addr);
            batch_left = batch_left - 1;
        end

        // The block halts for good on the first error or end record, so one is sent last.
        case ($urandom_range(0, 3))
            0:       bad = 8'($urandom_range(8'h00, 8'h2f));
            1:       bad = 8'($urandom_range(8'h3a, 8'h40));
            2:       bad = 8'($urandom_range(8'h47, 8'h60));
            default: bad = 8'($urandom_range(8'h67, 8'hff));
        endcase
        case ($urandom_range(0, 5))
            0:
            begin
                send_char(srl_pkg::CHAR_S);
                send_char(srl_pkg::CHAR_NINE);
            end
            1:
            begin
                // A newline here stands for an empty line.
                c = 8'($urandom_range(0, 255));
                send_char(c == srl_pkg::CHAR_S ? srl_pkg::CHAR_NEWLINE : c);
            end
            2:
            begin
                c = 8'($urandom_range(0, 255));
                send_char(srl_pkg::CHAR_S);
                send_char((c == srl_pkg::CHAR_ONE || c == srl_pkg::CHAR_NINE) ? 8'h30 : c);
            end
            3:
            begin
                send_char(srl_pkg::CHAR_S);
                send_char(srl_pkg::CHAR_ONE);
                send_hex(16'($urandom_range(0, 15)), int'($urandom_range(0, 1)));
                send_char(bad);
            end
            4:
            begin
                send_char(srl_pkg::CHAR_S);
                send_char(srl_pkg::CHAR_ONE);
                send_hex(16'($urandom_range(0, 255)), 2);
                send_hex(16'($urandom_range(0, 16'hFFF)), int'($urandom_range(0, 3)));
                send_char(bad);
            end
            default:
            begin
                len    = int'($urandom_range(4, 20));
                nbytes = int'($urandom_range(0, len - 4));
                send_char(srl_pkg::CHAR_S);
                send_char(srl_pkg::CHAR_ONE);
                send_hex(16'(len), 2);
                send_hex(16'($urandom_range(0, 16'hFFFF)), 4);
                repeat (nbytes) send_hex(16'($urandom_range(0, 255)), 2);
                if ($urandom_range(0, 1) != 0)
                begin
                    send_char(hex_char(4'($urandom_range(0, 15))));
                end
                send_char(bad);
            end
        endcase

        // Once halted, offset writes are still taken and text gives nothing.
        drain;
        write_offset(16'($urandom_range(0, 16'hFFFF)));
        send_text("S10400");
        repeat (12) send_char(8'($urandom_range(0, 255)));
        drain;
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("srecord_loader_core test passed");
        end
        else
        begin
            $display("srecord_loader_core test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/srl_pkg.sv
design/srecord_loader_core.sv
tb/srecord_loader_checker.sv
tb/tb_srecord_loader_core.sv
